// ----- rtl/core/tfbe_pkg.sv -----
// ============================================================================
// tfbe_pkg
// Types and constants shared by the typed field byte encoder modules.
// ============================================================================
package tfbe_pkg;

    localparam int unsigned ACTION_W  = 4;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned GROUP_W   = 7;
    localparam int unsigned COUNT_W   = 4;

    localparam logic [GROUP_W-1:0] GROUP_MASK = 7'h7f;

    // Kinds of value selected by the action field.
    typedef enum logic [ACTION_W-1:0] {
        ACT_BOOL      = 4'd0,
        ACT_INT8      = 4'd1,
        ACT_INT16     = 4'd2,
        ACT_INT32     = 4'd3,
        ACT_INT64     = 4'd4,
        ACT_UVARINT32 = 4'd5,
        ACT_UVARINT64 = 4'd6,
        ACT_SVARINT32 = 4'd7,
        ACT_SVARINT64 = 4'd8
    } action_t;

    // Input transaction payload.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
    } item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } result_t;

    // Classified job handed from the front end to the byte emitter.
    // For fixed-width kinds the word is left-aligned so that the first
    // byte to send sits in the top byte; for varints it holds the
    // (possibly zigzag-mapped) value whose low group goes first.
    typedef struct packed {
        logic               varint;
        logic [COUNT_W-1:0] nbytes;
        logic [VALUE_W-1:0] word;
    } job_t;

endpackage

// ----- rtl/core/tfbe_front.sv -----
// ============================================================================
// tfbe_front
// Accepts input transactions, decodes the kind of value and builds a job.
// ============================================================================
module tfbe_front
    import tfbe_pkg::*;
(
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    input  logic  queue_full,
    output logic  push,
    output job_t  job
);

    logic [VALUE_W-1:0] sext32;
    logic [VALUE_W-1:0] zz_src;
    logic [VALUE_W-1:0] zigzag;
    logic               known;

    assign item_ready = !queue_full;

    // Sign-extend a 32-bit value, then zigzag-map the chosen source.
    assign sext32 = {{32{item.value[31]}}, item.value[31:0]};
    assign zz_src = (action_t'(item.action) == ACT_SVARINT32) ? sext32 : item.value;
    assign zigzag = {zz_src[VALUE_W-2:0], 1'b0} ^ {VALUE_W{zz_src[VALUE_W-1]}};

    always_comb
    begin
        job   = '0;
        known = 1'b1;
        unique case (action_t'(item.action))
            ACT_BOOL:
            begin
                job.nbytes = 4'd1;
                job.word   = {7'd0, |item.value, 56'd0};
            end
            ACT_INT8:
            begin
                job.nbytes = 4'd1;
                job.word   = {item.value[7:0], 56'd0};
            end
            ACT_INT16:
            begin
                job.nbytes = 4'd2;
                job.word   = {item.value[15:0], 48'd0};
            end
            ACT_INT32:
            begin
                job.nbytes = 4'd4;
                job.word   = {item.value[31:0], 32'd0};
            end
            ACT_INT64:
            begin
                job.nbytes = 4'd8;
                job.word   = item.value;
            end
            ACT_UVARINT32:
            begin
                job.varint = 1'b1;
                job.word   = {32'd0, item.value[31:0]};
            end
            ACT_UVARINT64:
            begin
                job.varint = 1'b1;
                job.word   = item.value;
            end
            ACT_SVARINT32, ACT_SVARINT64:
            begin
                job.varint = 1'b1;
                job.word   = zigzag;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // Unknown kinds are accepted and dropped since they produce no bytes.
    assign push = item_valid && item_ready && known;

endmodule

// ----- rtl/core/tfbe_queue.sv -----
// ============================================================================
// tfbe_queue
// Small first-in first-out buffer of jobs between front end and emitter.
// ============================================================================
module tfbe_queue
    import tfbe_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/core/tfbe_back.sv -----
// ============================================================================
// tfbe_back
// Takes one job at a time and emits its bytes into an output register.
// ============================================================================
module tfbe_back
    import tfbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    queue_empty,
    input  job_t    head,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic               busy_reg;
    logic               varint_reg;
    logic [COUNT_W-1:0] left_reg;
    logic [VALUE_W-1:0] word_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic               advance;
    logic               is_last;
    logic [BYTE_W-1:0]  cur_byte;

    assign pop     = !busy_reg && !queue_empty;
    assign advance = busy_reg && (!out_valid_reg || result_ready);

    // A varint ends when no bits remain above the current group; a final
    // group carries the mark in bit 7.
    always_comb
    begin
        if (varint_reg)
        begin
            is_last  = (word_reg[VALUE_W-1:GROUP_W] == '0);
            cur_byte = {is_last, word_reg[GROUP_W-1:0] & GROUP_MASK};
        end
        else
        begin
            is_last  = (left_reg == COUNT_W'(1));
            cur_byte = word_reg[VALUE_W-1:VALUE_W-BYTE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (advance && is_last)
            begin
                busy_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            varint_reg <= head.varint;
            left_reg   <= head.nbytes;
            word_reg   <= head.word;
        end
        else if (advance)
        begin
            left_reg <= left_reg - 1'b1;
            word_reg <= varint_reg ? (word_reg >> GROUP_W) : (word_reg << BYTE_W);
        end

        if (advance)
        begin
            out_reg.out_byte  <= cur_byte;
            out_reg.last_byte <= is_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- rtl/core/typed_field_byte_encoder.sv -----
// ============================================================================
// typed_field_byte_encoder
// Serializes one typed value per input transaction into a stream of bytes.
// ============================================================================
// Each input transaction carries an action code and a 64-bit value, and the
// block answers with one output transaction per serialized byte, marking the
// final byte with last_byte. A bool gives a single byte (1 if any bit of the
// value is set), the fixed-width integers give 1, 2, 4 or 8 bytes most
// significant first, and varints give 7-bit groups lowest first with bit 7
// set only on the final group; signed varints are zigzag-mapped over 64 bits
// after a 32-bit value is sign-extended. Unknown action codes are accepted
// and produce nothing. A front end decodes each transaction into a job and
// places it in a short queue, so new transactions are taken while earlier
// values are still being sent; the emitter behind it loads one job and then
// sends one byte per cycle while the consumer accepts them, and it loads the
// next job only after the last byte of the current one has been sent. The
// emitter's output register decouples it from the consumer, and a stalled
// consumer holds the emitter without losing data.
module typed_field_byte_encoder
    import tfbe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    job_t front_job;
    job_t head_job;
    logic push;
    logic pop;
    logic queue_empty;
    logic queue_full;

    // Front end: accepts transactions and classifies them into jobs.
    tfbe_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .job        (front_job)
    );

    // Job queue that lets the front end and the emitter stall independently.
    tfbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head     (head_job),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // Emitter: walks through each job one byte per cycle while the consumer accepts them.
    tfbe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .head         (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- verif/tb_typed_field_byte_encoder.sv -----
// ============================================================================
// tb_typed_field_byte_encoder
// Self-checking testbench for the typed field byte encoder.
// ============================================================================
// A short directed list is sent first. It covers every action, the field
// extremes, wide bool values, ignored upper bits, the zero varint, the
// ten-byte varints and the unused action codes. After a pause that lets the
// block drain completely, a random set of values follows, shaped so that
// varint lengths and fixed-width sign patterns vary widely. The
// predictor builds the expected byte stream for every accepted transaction,
// and the monitor checks each output transaction against the oldest
// expected byte.
// ============================================================================
module tb_typed_field_byte_encoder
    import tfbe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Action codes that the block accepts but answers with no bytes.
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

    localparam int N_RANDOM      = 96;
    localparam int TAIL_ITEMS    = 20;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 120;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // Values waiting to be offered, and the bytes the block still owes us.
    item_t   pending_items[$];
    result_t expected_bytes[$];

    int      items_accepted;
    int      results_seen;
    int      errors;
    int      tail_start   = 32'h7fff_ffff;
    int      cycle_count;
    logic    calm;
    int      send_gap;
    int      stall_left;
    int      hold_left;
    logic    long_hold_done;
    result_t want;

    typed_field_byte_encoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Appends one byte to the stream the block still owes.
    function automatic void expect_byte(result_t r);
        expected_bytes.insert(expected_bytes.size(), r);
    endfunction

    // Queues the expected bytes of a fixed-width integer, most significant
    // byte first.
    function automatic void push_big_endian(logic [VALUE_W-1:0] v, int nbytes);
        result_t r;
        for (int i = 0; i < nbytes; i++)
        begin
            r.out_byte  = v[8 * (nbytes - 1 - i) +: 8];
            r.last_byte = (i == nbytes - 1);
            expect_byte(r);
        end
    endfunction

    // Queues the expected 7-bit groups, lowest first. In this format bit 7
    // marks the final group, not the groups that continue.
    function automatic void push_varint(logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] rest;
        result_t            r;
        int                 n;
        rest = v;
        n    = 0;
        do
        begin
            r.out_byte = {1'b0, rest[GROUP_W-1:0]};
            rest       = rest >> GROUP_W;
            if (rest == '0)
                r.out_byte[7] = 1'b1;
            r.last_byte = (rest == '0);
            expect_byte(r);
            n++;
        end
        while (rest != '0 && n < 10);
    endfunction

    function automatic logic [VALUE_W-1:0] zigzag_map(logic [VALUE_W-1:0] v);
        return (v << 1) ^ {VALUE_W{v[VALUE_W-1]}};
    endfunction

    function automatic void encode_to_bytes(item_t it);
        result_t r;
        case (it.action)
            ACT_BOOL:
            begin
                r.out_byte  = (it.value != '0) ? 8'd1 : 8'd0;
                r.last_byte = 1'b1;
                expect_byte(r);
            end
            ACT_INT8:      push_big_endian({56'd0, it.value[7:0]}, 1);
            ACT_INT16:     push_big_endian({48'd0, it.value[15:0]}, 2);
            ACT_INT32:     push_big_endian({32'd0, it.value[31:0]}, 4);
            ACT_INT64:     push_big_endian(it.value, 8);
            ACT_UVARINT32: push_varint({32'd0, it.value[31:0]});
            ACT_UVARINT64: push_varint(it.value);
            ACT_SVARINT32: push_varint(zigzag_map({{32{it.value[31]}}, it.value[31:0]}));
            ACT_SVARINT64: push_varint(zigzag_map(it.value));
            default:
            begin
                // Unused codes are consumed without any output.
            end
        endcase
    endfunction

    function automatic item_t make_item(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val);
        item_t it;
        it.action = act;
        it.value  = val;
        return it;
    endfunction

    // Adds one value to the list the driver offers.
    function automatic void queue_item(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val);
        pending_items.insert(pending_items.size(), make_item(act, val));
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the pending values one at a time. The gap counter puts
    // idle bursts between transactions, and none once the tail is reached.
    // A valid transaction is only replaced when it has been accepted.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid     <= 1'b0;
            item           <= '0;
            send_gap       <= 0;
            items_accepted <= 0;
            calm           <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                encode_to_bytes(item);
                items_accepted <= items_accepted + 1;
            end
            if (!item_valid || item_ready)
            begin
                if (send_gap != 0)
                begin
                    item_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 13);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
            calm <= (items_accepted >= tail_start);
        end
    end

    // ------------------------------------------------------------------------
    // Long hold-off: once enough bytes have come out, this counter keeps the
    // receiver away for a long stretch so that the internal queue fills and
    // the input stalls while the driver keeps offering values.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!long_hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks every accepted output transaction and drives ready.
    // ------------------------------------------------------------------------
    task automatic note_error(string what, result_t exp_r, result_t got_r);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("[%0t] %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, what, exp_r.out_byte, exp_r.last_byte,
                     got_r.out_byte, got_r.last_byte);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready   <= 1'b0;
            results_seen   <= 0;
            stall_left     <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_bytes.size() == 0)
                begin
                    note_error("unexpected byte", '0, result);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (result.out_byte !== want.out_byte
                        || result.last_byte !== want.last_byte)
                        note_error("byte mismatch", want, result);
                end
            end

            if (hold_left != 0 || (!long_hold_done && results_seen >= HOLD_AFTER))
            begin
                result_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                result_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left   <= $urandom_range(0, 12);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // The run is ended here when cycle_count reaches CYCLE_LIMIT, so a block that stops making progress cannot hang it.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        item_t              random_items[$];
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  raw;
        logic [VALUE_W-1:0]  span;
        logic [VALUE_W-1:0]  val;
        int                  width;
        int                  kept;
        int                  n_unused;
        int                  n_directed;
        int                  total;

        cycle_count = 0;
        errors      = 0;

        // Directed values: field extremes, wide bools, ignored upper bits,
        // the zero varint, ten-byte varints and unused action codes.
        queue_item(ACT_BOOL,      64'd0);
        queue_item(ACT_BOOL,      64'h8000_0000_0000_0000);
        queue_item(ACT_INT8,      64'd0);
        queue_item(ACT_INT8,      64'hffff_ffff_ffff_ff80);
        queue_item(ACT_INT16,     64'h5a5a_5a5a_5a5a_8001);
        queue_item(ACT_INT32,     64'hffff_ffff_8000_0000);
        queue_item(ACT_INT32,     64'h0000_0000_7fff_ffff);
        queue_item(ACT_INT64,     64'hffff_ffff_ffff_ffff);
        queue_item(ACT_INT64,     64'h0123_4567_89ab_cdef);
        queue_item(ACT_UVARINT32, 64'hffff_ffff_0000_0000);
        queue_item(ACT_UVARINT32, 64'ha5a5_a5a5_ffff_ffff);
        queue_item(ACT_UVARINT64, 64'hffff_ffff_ffff_ffff);
        queue_item(ACT_UVARINT64, 64'h0000_0000_0000_007f);
        queue_item(ACT_UVARINT64, 64'h0000_0000_0000_0080);
        queue_item(ACT_SVARINT32, 64'h0000_0000_ffff_ffff);
        queue_item(ACT_SVARINT32, 64'h1234_5678_8000_0000);
        queue_item(ACT_SVARINT32, 64'hffff_ffff_7fff_ffff);
        queue_item(ACT_SVARINT64, 64'h8000_0000_0000_0000);
        queue_item(ACT_SVARINT64, 64'h7fff_ffff_ffff_ffff);
        queue_item(ACT_SVARINT64, 64'hffff_ffff_ffff_ffff);
        queue_item(ACT_SVARINT64, 64'd0);
        queue_item(ACT_UNUSED_LO, 64'hffff_ffff_ffff_ffff);
        queue_item(ACT_UNUSED_HI, 64'd1);
        n_directed = pending_items.size();

        // Random values. Widths are drawn first so that short and long
        // varints, small negatives and wide garbage bits all turn up often.
        // Unused action codes are mixed in but do not count toward the set.
        kept     = 0;
        n_unused = 0;
        while (kept < N_RANDOM)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                act = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
                n_unused++;
            end
            else
            begin
                act = ACTION_W'($urandom_range(ACT_BOOL, ACT_SVARINT64));
                kept++;
            end
            width = $urandom_range(0, 64);
            span  = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
            raw   = {$urandom(), $urandom()};
            case ($urandom_range(0, 4))
                0:       val = raw;
                1, 2:    val = raw & span;
                3:       val = raw | ~span;
                default: val = 64'($urandom_range(0, 1));
            endcase
            random_items.insert(random_items.size(), make_item(act, val));
        end
        total      = n_directed + random_items.size();
        tail_start = total - TAIL_ITEMS;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // The sender pauses here until every directed byte has come out,
        // then waits for DRAIN_CYCLES before the random values are queued.
        while (items_accepted < n_directed || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        foreach (random_items[i])
            pending_items.insert(pending_items.size(), random_items[i]);

        while (items_accepted < total || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_bytes.size() != 0)
        begin
            errors += expected_bytes.size();
            $display("%0d expected bytes never arrived", expected_bytes.size());
        end

        $display("sent %0d values (%0d directed, %0d with unused action codes), checked %0d bytes",
                 total, n_directed, n_unused + 2, results_seen);
        $display("%0d errors over %0d cycles, including one long receiver hold-off",
                 errors, cycle_count);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tfbe_pkg.sv
rtl/core/tfbe_front.sv
rtl/core/tfbe_queue.sv
rtl/core/tfbe_back.sv
rtl/core/typed_field_byte_encoder.sv
verif/tb_typed_field_byte_encoder.sv
